/* hw/rtl/adcpp_pkg.sv */
// Shared types, operation codes and the bus pin map of the ADC ping-pong capture unit.
package adcpp_pkg;

    // Operation codes carried on op
    typedef enum logic [2:0] {
        OP_ARM     = 3'd0,
        OP_SAMPLE  = 3'd1,
        OP_READ    = 3'd2,
        OP_START   = 3'd3,
        OP_RELEASE = 3'd4,
        OP_HALT    = 3'd5
    } op_t;

    localparam int SAMPLE_W = 16;
    localparam int RAW_W    = 32;
    localparam int ADDR_W   = 13;
    localparam int CHAN_W   = 4;

    // Bus pin that carries each sample bit, bit 0 first
    localparam logic [4:0] PIN_OF_BIT [SAMPLE_W] = '{
        5'd3,  5'd4,  5'd14, 5'd15, 5'd17, 5'd18, 5'd27, 5'd22,
        5'd23, 5'd24, 5'd10, 5'd9,  5'd25, 5'd8,  5'd11, 5'd7
    };

    // Status and payload of one result, registered in the controller
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                from_mem;
        logic [ADDR_W-1:0]   write_address;
        logic                head_page;
        logic                tail_page;
        logic                page_done;
        logic                page_ready;
        logic                overrun;
        logic                running;
        logic                armed;
    } res_t;

    // Gather the sample bits from their bus pins
    function automatic logic [SAMPLE_W-1:0] unswizzle(input logic [RAW_W-1:0] word);
        logic [SAMPLE_W-1:0] res;
        res = '0;
        for (int k = 0; k < SAMPLE_W; k++) begin
            res[k] = word[PIN_OF_BIT[k]];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/adcpp_store.sv */
// Two-page sample store: one write port, one registered read port.
module adcpp_store #(
    parameter int MEM_AW = 14
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [MEM_AW-1:0]              wr_addr,
    input  logic [adcpp_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                           rd_en,
    input  logic [MEM_AW-1:0]              rd_addr,
    output logic [adcpp_pkg::SAMPLE_W-1:0] rd_data
);

    logic [adcpp_pkg::SAMPLE_W-1:0] mem [2**MEM_AW];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/adcpp_ctrl.sv */
// Capture controller: page indices, run flags, fill length and the result register.
module adcpp_ctrl #(
    parameter int PAGE_WORDS   = 8192,
    parameter int MAX_CHANNELS = 8,
    parameter int IDX_W        = 13
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [2:0]                     op,
    input  logic [adcpp_pkg::RAW_W-1:0]    raw_word,
    input  logic [adcpp_pkg::ADDR_W-1:0]   read_address,
    input  logic                           channel_count_we,
    input  logic [adcpp_pkg::CHAN_W-1:0]   channel_count,
    output logic                           mem_wr_en,
    output logic [IDX_W:0]                 mem_wr_addr,
    output logic [adcpp_pkg::SAMPLE_W-1:0] mem_wr_data,
    output logic                           mem_rd_en,
    output logic [IDX_W:0]                 mem_rd_addr,
    output logic                           res_strobe,
    output adcpp_pkg::res_t                res
);

    localparam int LEN_W = IDX_W + 1;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RESET_LEN = (MAX_CHANNELS >= 8) ? (PAGE_WORDS / 8) * 8 : PAGE_WORDS;

    adcpp_pkg::op_t op_q;

    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             head_reg, head_next;
    logic             tail_reg, tail_next;
    logic             run_reg, run_next;
    logic             ovr_reg, ovr_next;
    logic             arm_reg, arm_next;
    logic [LEN_W-1:0] len_reg;

    adcpp_pkg::res_t  res_reg, res_next;
    logic             strobe_reg;

    logic [LEN_W-1:0] len_tab [MAX_CHANNELS];
    logic             last;
    logic             ch_ok;

    // whole-tuple fill length for each legal channel count
    for (genvar g = 0; g < MAX_CHANNELS; g++)
    begin : g_len
        localparam int TUPLE_LEN = (PAGE_WORDS / (g + 1)) * (g + 1);
        assign len_tab[g] = LEN_W'(TUPLE_LEN);
    end

    assign ch_ok = ({1'b0, channel_count} >= 5'd1) &&
                   ({1'b0, channel_count} <= 5'(MAX_CHANNELS));

    // fill length register, illegal counts leave it alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(RESET_LEN);
        end
        else if (channel_count_we && ch_ok)
        begin
            len_reg <= len_tab[CH_W'(channel_count - 4'd1)];
        end
    end

    assign op_q = adcpp_pkg::op_t'(op);
    // page is full once this write reaches the fill length (or lies past it)
    assign last = ((LEN_W'(fill_reg) + LEN_W'(1)) >= len_reg);

    // next state and result of one operation
    always_comb
    begin
        fill_next   = fill_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        run_next    = run_reg;
        ovr_next    = ovr_reg;
        arm_next    = arm_reg;
        res_next    = '0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_data = adcpp_pkg::unswizzle(raw_word);
        mem_wr_addr = {head_reg, fill_reg};
        mem_rd_addr = {tail_reg, IDX_W'(read_address)};

        case (op_q)
            adcpp_pkg::OP_ARM:
            begin
                fill_next = '0;
                head_next = 1'b0;
                tail_next = 1'b0;
                run_next  = 1'b0;
                ovr_next  = 1'b0;
                arm_next  = 1'b1;
            end
            adcpp_pkg::OP_SAMPLE:
            begin
                res_next.sample = mem_wr_data;
                if (run_reg)
                begin
                    mem_wr_en              = accept;
                    res_next.write_address = adcpp_pkg::ADDR_W'(fill_reg);
                    if (last)
                    begin
                        fill_next          = '0;
                        head_next          = ~head_reg;
                        res_next.page_done = 1'b1;
                        if (~head_reg == tail_reg)
                        begin
                            ovr_next = 1'b1;
                            run_next = 1'b0;
                        end
                    end
                    else
                    begin
                        fill_next = fill_reg + IDX_W'(1);
                    end
                end
            end
            adcpp_pkg::OP_READ:
            begin
                if (!ovr_reg)
                begin
                    mem_rd_en         = accept;
                    res_next.from_mem = 1'b1;
                end
            end
            adcpp_pkg::OP_START:
            begin
                if (arm_reg && !run_reg)
                begin
                    run_next = 1'b1;
                    arm_next = 1'b0;
                end
            end
            adcpp_pkg::OP_RELEASE:
            begin
                if (!ovr_reg && (head_reg != tail_reg))
                begin
                    tail_next = ~tail_reg;
                end
            end
            adcpp_pkg::OP_HALT:
            begin
                run_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        res_next.head_page  = head_next;
        res_next.tail_page  = tail_next;
        res_next.page_ready = (head_next != tail_next);
        res_next.overrun    = ovr_next;
        res_next.running    = run_next;
        res_next.armed      = arm_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            head_reg   <= 1'b0;
            tail_reg   <= 1'b0;
            run_reg    <= 1'b0;
            ovr_reg    <= 1'b0;
            arm_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= accept;
            if (accept)
            begin
                fill_reg <= fill_next;
                head_reg <= head_next;
                tail_reg <= tail_next;
                run_reg  <= run_next;
                ovr_reg  <= ovr_next;
                arm_reg  <= arm_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

    // overrun always stops acquisition
    a_ovr_stops: assert property (@(posedge clk) disable iff (!rst_n)
        ovr_reg |-> !run_reg)
        else $error("overrun set while running");

    // armed and running are never both set
    a_arm_run: assert property (@(posedge clk) disable iff (!rst_n)
        !(arm_reg && run_reg))
        else $error("armed while running");

    // completing a page flips the head page
    a_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_q == adcpp_pkg::OP_SAMPLE) && run_reg && last)
        |=> (head_reg != $past(head_reg)))
        else $error("head page did not flip on page completion");

    // every transfer in gives a result in the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_strobe)
        else $error("missing result strobe");

    // a read never overlaps a store write
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("store written and read in one cycle");

endmodule

/* hw/rtl/adc_ping_pong_capture_unit.sv */
// Top level of the ADC ping-pong capture unit: controller, sample store and result select.
//
// One operation is taken in every clock cycle: busy stays low, so a start pulse is always a
// transfer. Its result appears on the result ports, marked by result_strobe, in the cycle after
// the transfer and for that cycle alone; the receiver cannot stall it. The read port of the
// sample store is registered and serves tail-page reads, while sample writes go into the head
// page at the transfer edge. The store holds two pages of PAGE_WORDS samples each;
// PAGE_WORDS is a power of two and read_address wraps within a page. The store has no reset
// and needs no clearing pass. channel_count (1 to MAX_CHANNELS) is written with
// channel_count_we; other values are dropped.
module adc_ping_pong_capture_unit #(
    parameter int PAGE_WORDS   = 8192,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     op,
    input  logic [adcpp_pkg::RAW_W-1:0]    raw_word,
    input  logic [adcpp_pkg::ADDR_W-1:0]   read_address,
    input  logic                           channel_count_we,
    input  logic [adcpp_pkg::CHAN_W-1:0]   channel_count,
    output logic                           result_strobe,
    output logic [adcpp_pkg::SAMPLE_W-1:0] sample,
    output logic [adcpp_pkg::ADDR_W-1:0]   write_address,
    output logic                           head_page,
    output logic                           tail_page,
    output logic                           page_done,
    output logic                           page_ready,
    output logic                           overrun,
    output logic                           running,
    output logic                           armed
);

    localparam int IDX_W = $clog2(PAGE_WORDS);

    logic                           accept;
    logic                           mem_wr_en;
    logic [IDX_W:0]                 mem_wr_addr;
    logic [adcpp_pkg::SAMPLE_W-1:0] mem_wr_data;
    logic                           mem_rd_en;
    logic [IDX_W:0]                 mem_rd_addr;
    logic [adcpp_pkg::SAMPLE_W-1:0] mem_rd_data;
    adcpp_pkg::res_t                res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    adcpp_ctrl #(
        .PAGE_WORDS   (PAGE_WORDS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .op               (op),
        .raw_word         (raw_word),
        .read_address     (read_address),
        .channel_count_we (channel_count_we),
        .channel_count    (channel_count),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .res_strobe       (result_strobe),
        .res              (res)
    );

    adcpp_store #(
        .MEM_AW (IDX_W + 1)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // stored word for reads, registered sample otherwise
    assign sample        = res.from_mem ? mem_rd_data : res.sample;
    assign write_address = res.write_address;
    assign head_page     = res.head_page;
    assign tail_page     = res.tail_page;
    assign page_done     = res.page_done;
    assign page_ready    = res.page_ready;
    assign overrun       = res.overrun;
    assign running       = res.running;
    assign armed         = res.armed;

endmodule

/* dv/adc_ping_pong_capture_unit_test.sv */
// Self-checking testbench for the ADC ping-pong capture unit: directed and random transfers.
module adc_ping_pong_capture_unit_test;

    localparam int CLK_PERIOD   = 20;
    localparam int PAGE_WORDS   = 8192;
    localparam int MAX_CHANNELS = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_EDGES = 3;
    localparam int REPORT_CAP   = 100;

    // Op codes the block must treat as no-ops
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // Bus pin feeding each sample bit, bit 0 first
    localparam int BUS_PIN [16] = '{3, 4, 14, 15, 17, 18, 27, 22,
                                    23, 24, 10, 9, 25, 8, 11, 7};

    // Channel counts used during the mixed-operation stretch (legal and illegal)
    localparam int NOISE_CHANNELS [7] = '{2, 12, 4, 5, 10, 6, 14};

    typedef struct {
        int unsigned fill_pos;
        logic        head;
        logic        tail;
        logic        run;
        logic        ovr;
        logic        arm;
        logic [3:0]  chan;
    } capture_state_t;

    typedef struct {
        logic [15:0] sample;
        logic [12:0] write_address;
        logic        head_page;
        logic        tail_page;
        logic        page_done;
        logic        page_ready;
        logic        overrun;
        logic        running;
        logic        armed;
    } capture_result_t;

    typedef enum {ENTRY_OP, ENTRY_CFG, ENTRY_PAUSE} entry_kind_t;

    typedef struct {
        entry_kind_t kind;
        logic [2:0]  op_code;
        logic [31:0] word;
        logic [12:0] addr;
        logic [3:0]  chan;
        bit          steady;
    } pending_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  op = 3'd0;
    logic [31:0] raw_word = '0;
    logic [12:0] read_address = '0;
    logic        channel_count_we = 1'b0;
    logic [3:0]  channel_count = 4'd8;
    logic        result_strobe;
    logic [15:0] sample;
    logic [12:0] write_address;
    logic        head_page;
    logic        tail_page;
    logic        page_done;
    logic        page_ready;
    logic        overrun;
    logic        running;
    logic        armed;

    adc_ping_pong_capture_unit #(
        .PAGE_WORDS   (PAGE_WORDS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .raw_word         (raw_word),
        .read_address     (read_address),
        .channel_count_we (channel_count_we),
        .channel_count    (channel_count),
        .result_strobe    (result_strobe),
        .sample           (sample),
        .write_address    (write_address),
        .head_page        (head_page),
        .tail_page        (tail_page),
        .page_done        (page_done),
        .page_ready       (page_ready),
        .overrun          (overrun),
        .running          (running),
        .armed            (armed)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Capture behaviour
    // ---------------------------------------------------------------
    function automatic logic [15:0] bus_to_sample(input logic [31:0] w);
        logic [15:0] res;
        res = '0;
        for (int k = 0; k < 16; k++)
        begin
            res[k] = w[BUS_PIN[k]];
        end
        return res;
    endfunction

    // Whole channel tuples per page
    function automatic int unsigned page_fill_length(input logic [3:0] ch);
        int unsigned c;
        c = ch;
        return (PAGE_WORDS / c) * c;
    endfunction

    function automatic bit chan_legal(input logic [3:0] v);
        return v >= 1 && v <= MAX_CHANNELS;
    endfunction

    // Next state and status for one operation; stored marks a write at
    // write_address of the old head page. Read data is filled in by the caller.
    function automatic void capture_step(input capture_state_t s, input logic [2:0] op_code,
                                         input logic [31:0] word, output capture_state_t ns,
                                         output capture_result_t r, output bit stored);
        int unsigned pos;
        ns = s;
        stored = 0;
        r.sample = '0;
        r.write_address = '0;
        r.page_done = 1'b0;
        case (op_code)
            adcpp_pkg::OP_ARM:
            begin
                ns.fill_pos = 0;
                ns.head = 1'b0;
                ns.tail = 1'b0;
                ns.run = 1'b0;
                ns.ovr = 1'b0;
                ns.arm = 1'b1;
            end
            adcpp_pkg::OP_SAMPLE:
            begin
                r.sample = bus_to_sample(word);
                if (s.run)
                begin
                    pos = s.fill_pos % PAGE_WORDS;
                    stored = 1;
                    r.write_address = pos[12:0];
                    // a page past its fill length after a shrink counts as full
                    if (pos + 1 >= page_fill_length(s.chan))
                    begin
                        ns.fill_pos = 0;
                        ns.head = ~s.head;
                        r.page_done = 1'b1;
                        if (ns.head == s.tail)
                        begin
                            ns.ovr = 1'b1;
                            ns.run = 1'b0;
                        end
                    end
                    else
                    begin
                        ns.fill_pos = pos + 1;
                    end
                end
            end
            adcpp_pkg::OP_START:
            begin
                if (s.arm && !s.run)
                begin
                    ns.run = 1'b1;
                    ns.arm = 1'b0;
                end
            end
            adcpp_pkg::OP_RELEASE:
            begin
                if (!s.ovr && s.head != s.tail)
                    ns.tail = ~s.tail;
            end
            adcpp_pkg::OP_HALT:
            begin
                ns.run = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.head_page = ns.head;
        r.tail_page = ns.tail;
        r.page_ready = ns.head != ns.tail;
        r.overrun = ns.ovr;
        r.running = ns.run;
        r.armed = ns.arm;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus build: a shadow of the control state keeps reads on written entries
    // ---------------------------------------------------------------
    pending_entry_t pending_entries[$];
    capture_state_t plan_state = '{0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd8};
    int             plan_written [2] = '{0, 0};   // written prefix length per page

    task automatic add_op(input logic [2:0] op_code, input logic [31:0] word,
                          input logic [12:0] addr, input bit steady);
        capture_state_t  nxt;
        capture_result_t r;
        bit              stored;
        pending_entry_t  e;
        capture_step(plan_state, op_code, word, nxt, r, stored);
        if (stored && int'(r.write_address) + 1 > plan_written[plan_state.head])
            plan_written[plan_state.head] = int'(r.write_address) + 1;
        plan_state = nxt;
        e.kind = ENTRY_OP;
        e.op_code = op_code;
        e.word = word;
        e.addr = addr;
        e.chan = '0;
        e.steady = steady;
        pending_entries.push_back(e);
    endtask

    // Tail-page read of a written entry; a reserved op where nothing is written yet
    task automatic add_read(input bit steady);
        int filled;
        int pick;
        filled = plan_written[plan_state.tail];
        if (filled == 0)
        begin
            add_op(OP_RSVD6, $urandom, 13'($urandom), steady);
        end
        else
        begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                add_op(adcpp_pkg::OP_READ, $urandom, 13'(filled - 1), steady);
            else if (pick == 1)
                add_op(adcpp_pkg::OP_READ, $urandom, 13'd0, steady);
            else
                add_op(adcpp_pkg::OP_READ, $urandom, 13'($urandom_range(0, filled - 1)),
                       steady);
        end
    endtask

    task automatic add_cfg(input logic [3:0] v);
        pending_entry_t e;
        e.kind = ENTRY_CFG;
        e.op_code = adcpp_pkg::OP_ARM;
        e.word = '0;
        e.addr = '0;
        e.chan = v;
        e.steady = 0;
        pending_entries.push_back(e);
        if (chan_legal(v))
            plan_state.chan = v;
    endtask

    task automatic add_pause();
        pending_entry_t e;
        e.kind = ENTRY_PAUSE;
        e.op_code = adcpp_pkg::OP_ARM;
        e.word = '0;
        e.addr = '0;
        e.chan = '0;
        e.steady = 0;
        pending_entries.push_back(e);
    endtask

    // Sample stream with a reader reading and releasing the tail page now and then
    task automatic fill_run(input int n, input int reader_pct, input bit may_release,
                            input bit steady);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < reader_pct)
            begin
                if (may_release && plan_state.head != plan_state.tail
                    && $urandom_range(0, 2) == 0)
                    add_op(adcpp_pkg::OP_RELEASE, $urandom, 13'($urandom), steady);
                else
                    add_read(steady);
            end
            else
            begin
                add_op(adcpp_pkg::OP_SAMPLE, $urandom, 13'($urandom), steady);
            end
        end
    endtask

    task automatic add_mixed_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            add_op(adcpp_pkg::OP_SAMPLE, $urandom, 13'($urandom), 0);
        else if (pick < 67)
            add_read(0);
        else if (pick < 73)
            add_op(adcpp_pkg::OP_RELEASE, $urandom, 13'($urandom), 0);
        else if (pick < 79)
            add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        else if (pick < 87)
            add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        else if (pick < 92)
            add_op(adcpp_pkg::OP_HALT, $urandom, 13'($urandom), 0);
        else if (pick < 96)
            add_op(OP_RSVD6, $urandom, 13'($urandom), 0);
        else
            add_op(OP_RSVD7, $urandom, 13'($urandom), 0);
    endtask

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    capture_result_t expected_results[$];
    int          quiet_edges = 0;
    logic        nx_start;
    logic [2:0]  nx_op;
    logic [31:0] nx_word;
    logic [12:0] nx_addr;
    logic        nx_we;
    logic [3:0]  nx_chan;

    always @(posedge clk)
    begin
        nx_start = 1'b0;
        nx_we = 1'b0;
        nx_op = op;
        nx_word = raw_word;
        nx_addr = read_address;
        nx_chan = channel_count;
        if (!rst_n)
        begin
            quiet_edges = 0;
        end
        else if (start && busy)
        begin
            // transfer not taken yet: hold the item
            nx_start = 1'b1;
        end
        else
        begin
            // count edges with nothing in flight, for register writes and pauses
            if (start || channel_count_we || expected_results.size() != 0)
                quiet_edges = 0;
            else
                quiet_edges++;
            if (pending_entries.size() != 0)
            begin
                case (pending_entries[0].kind)
                    ENTRY_OP:
                    begin
                        if (pending_entries[0].steady || $urandom_range(0, 99) >= 14)
                        begin
                            nx_start = 1'b1;
                            nx_op = pending_entries[0].op_code;
                            nx_word = pending_entries[0].word;
                            nx_addr = pending_entries[0].addr;
                            void'(pending_entries.pop_front());
                        end
                    end
                    ENTRY_CFG:
                    begin
                        if (quiet_edges >= SETTLE_EDGES)
                        begin
                            nx_we = 1'b1;
                            nx_chan = pending_entries[0].chan;
                            quiet_edges = 0;
                            void'(pending_entries.pop_front());
                        end
                    end
                    default:
                    begin
                        if (quiet_edges >= SETTLE_EDGES)
                            void'(pending_entries.pop_front());
                    end
                endcase
            end
        end
        start <= nx_start;
        op <= nx_op;
        raw_word <= nx_word;
        read_address <= nx_addr;
        channel_count_we <= nx_we;
        channel_count <= nx_chan;
    end

    // ---------------------------------------------------------------
    // Monitor: checks results, then predicts for the transfer at this edge
    // ---------------------------------------------------------------
    capture_state_t  live_state = '{0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd8};
    logic [15:0]     page_mem [0:2*PAGE_WORDS-1];
    int              mismatches = 0;
    capture_state_t  live_next;
    capture_result_t live_result;
    capture_result_t oldest;
    bit              live_stored;

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatches < REPORT_CAP)
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $error("result with no transfer outstanding, sample 0x%0h", sample);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("sample", 32'(oldest.sample), 32'(sample));
                    check_field("write_address", 32'(oldest.write_address),
                                32'(write_address));
                    check_field("head_page", 32'(oldest.head_page), 32'(head_page));
                    check_field("tail_page", 32'(oldest.tail_page), 32'(tail_page));
                    check_field("page_done", 32'(oldest.page_done), 32'(page_done));
                    check_field("page_ready", 32'(oldest.page_ready), 32'(page_ready));
                    check_field("overrun", 32'(oldest.overrun), 32'(overrun));
                    check_field("running", 32'(oldest.running), 32'(running));
                    check_field("armed", 32'(oldest.armed), 32'(armed));
                end
            end
            if (channel_count_we && chan_legal(channel_count))
                live_state.chan = channel_count;
            if (start && !busy)
            begin
                capture_step(live_state, op, raw_word, live_next, live_result, live_stored);
                if (live_stored)
                    page_mem[{live_state.head, live_result.write_address}] = live_result.sample;
                if (op == adcpp_pkg::OP_READ && !live_state.ovr)
                    live_result.sample = page_mem[{live_state.tail, read_address}];
                live_state = live_next;
                expected_results.push_back(live_result);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int waited;

        // illegal channel counts leave the reset value in place
        add_cfg(4'd0);
        add_cfg(4'd15);
        add_cfg(4'd9);

        // directed: idle block, arming, first samples and reads
        add_op(adcpp_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 13'h1FFF, 0);
        add_op(adcpp_pkg::OP_SAMPLE, 32'h0000_0000, 13'h0000, 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_RELEASE, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_HALT, $urandom, 13'($urandom), 0);
        add_op(OP_RSVD6, 32'hFFFF_FFFF, 13'h1FFF, 0);
        add_op(OP_RSVD7, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_SAMPLE, 32'h0000_0000, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_SAMPLE, 32'hAAAA_AAAA, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_SAMPLE, 32'h5555_5555, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_READ, $urandom, 13'd0, 0);
        add_op(adcpp_pkg::OP_READ, $urandom, 13'd3, 0);
        add_op(adcpp_pkg::OP_RELEASE, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_HALT, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_SAMPLE, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        add_read(0);

        // one channel: sample stream with a prompt reader, first stretch gapless
        add_cfg(4'd1);
        add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        fill_run(150, 3, 1, 1);
        fill_run(150, 3, 1, 0);
        add_op(adcpp_pkg::OP_HALT, $urandom, 13'($urandom), 0);

        // eight channels after a full drain, busy reader
        add_pause();
        add_cfg(4'd8);
        add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        fill_run(60, 20, 1, 0);
        add_op(adcpp_pkg::OP_HALT, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        add_read(0);

        // channel count changes in the middle of a page
        add_op(adcpp_pkg::OP_ARM, $urandom, 13'($urandom), 0);
        add_op(adcpp_pkg::OP_START, $urandom, 13'($urandom), 0);
        fill_run(30, 5, 1, 0);
        add_cfg(4'd3);
        add_op(adcpp_pkg::OP_SAMPLE, $urandom, 13'($urandom), 0);
        add_read(0);
        add_op(adcpp_pkg::OP_RELEASE, $urandom, 13'($urandom), 0);
        add_cfg(4'd7);
        fill_run(40, 5, 1, 0);

        // mixed operations with channel count changes
        for (int i = 0; i < 180; i++)
        begin
            if (i % 40 == 20)
                add_cfg(4'(NOISE_CHANNELS[(i / 40) % 7]));
            add_mixed_op();
        end

        // wait for the last transfer, then for its result
        while (pending_entries.size() != 0 || start)
            @(posedge clk);
        waited = 0;
        while (expected_results.size() != 0 && waited < 100)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* adc_ping_pong_capture_unit.f */
hw/rtl/adcpp_pkg.sv
hw/rtl/adcpp_store.sv
hw/rtl/adcpp_ctrl.sv
hw/rtl/adc_ping_pong_capture_unit.sv
dv/adc_ping_pong_capture_unit_test.sv
